[hw/rtl/dtp_pkg.sv]
// ----------------------------------------------------------------------------
// dtp_pkg
// Widths, reset values, ramp segment codes and stage payload types for the
// depth threshold pseudocolor block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtp_pkg;

  localparam int unsigned DEPTH_W  = 11;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned SQ_W     = 2 * DEPTH_W;
  localparam int unsigned CUBE_W   = 3 * DEPTH_W;
  localparam int unsigned SCALED_W = CUBE_W + 4;
  localparam int unsigned GAMMA_SH = 23;
  localparam int unsigned LEVEL_W  = SCALED_W - GAMMA_SH;
  localparam int unsigned SEG_W    = LEVEL_W - CHAN_W;

  localparam logic [DEPTH_W-1:0] LIMIT_RESET = 11'd1024;
  localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'hFF;

  localparam logic [SEG_W-1:0] SEG_WHITE_RED   = 6'd0;
  localparam logic [SEG_W-1:0] SEG_RED_YELLOW  = 6'd1;
  localparam logic [SEG_W-1:0] SEG_YELLOW_GRN  = 6'd2;
  localparam logic [SEG_W-1:0] SEG_GRN_CYAN    = 6'd3;
  localparam logic [SEG_W-1:0] SEG_CYAN_BLUE   = 6'd4;
  localparam logic [SEG_W-1:0] SEG_BLUE_DARK   = 6'd5;

  localparam logic REG_DEPTH_LIMIT = 1'b0;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [LEVEL_W-1:0] level;
  } gamma_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic [DEPTH_W-1:0] depth;
  } pix_t;

endpackage

[hw/rtl/dtp_apb_regs.sv]
// ----------------------------------------------------------------------------
// dtp_apb_regs
// APB register file holding the depth limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtp_apb_regs
  import dtp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [DEPTH_W-1:0] depth_limit_o
);

  logic [DEPTH_W-1:0] limit_q, limit_d;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DEPTH_LIMIT);

  always_comb begin
    limit_d = limit_q;
    if (wr_en) begin
      limit_d = pwdata[DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DEPTH_LIMIT) begin
      prdata = {{(32-DEPTH_W){1'b0}}, limit_q};
    end
  end

  assign depth_limit_o = limit_q;

endmodule

[hw/rtl/dtp_gamma.sv]
// ----------------------------------------------------------------------------
// dtp_gamma
// Three-stage threshold and cubic gamma: clamp and square, cube, scale by 9
// and drop 23 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtp_gamma
  import dtp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [DEPTH_W-1:0] depth_limit_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [DEPTH_W-1:0] in_depth_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gamma_t             out_o
);

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  logic [DEPTH_W-1:0]  d1_q, d2_q, d3_q;
  logic [DEPTH_W-1:0]  d1_d;
  logic [SQ_W-1:0]     sq_q, sq_d;
  logic [CUBE_W-1:0]   cube_q, cube_d;
  logic [SCALED_W-1:0] scaled;
  logic [LEVEL_W-1:0]  level_q, level_d;

  assign adv3       = !v3_q || out_ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_comb begin
    d1_d   = (in_depth_i > depth_limit_i) ? '0 : in_depth_i;
    sq_d   = SQ_W'(d1_d) * SQ_W'(d1_d);
    cube_d = CUBE_W'(sq_q) * CUBE_W'(d1_q);
    scaled = SCALED_W'({cube_q, 3'b000}) + SCALED_W'(cube_q);
    level_d = scaled[SCALED_W-1:GAMMA_SH];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      d1_q <= d1_d;
      sq_q <= sq_d;
    end
    if (adv2) begin
      d2_q   <= d1_q;
      cube_q <= cube_d;
    end
    if (adv3) begin
      d3_q    <= d2_q;
      level_q <= level_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_o.depth = d3_q;
  assign out_o.level = level_q;

endmodule

[hw/rtl/dtp_ramp.sv]
// ----------------------------------------------------------------------------
// dtp_ramp
// Output stage: maps a gamma level onto the six-segment color ramp and holds
// the finished pixel for the downstream receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtp_ramp
  import dtp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  gamma_t in_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output pix_t   out_o
);

  logic              v_q;
  logic              adv;
  pix_t              pix_q, pix_d;
  logic [CHAN_W-1:0] lb, lb_inv;
  logic [SEG_W-1:0]  seg;

  assign adv        = !v_q || out_ready_i;
  assign in_ready_o = adv;

  assign lb     = in_i.level[CHAN_W-1:0];
  assign lb_inv = CHAN_MAX - lb;
  assign seg    = in_i.level[LEVEL_W-1:CHAN_W];

  always_comb begin
    pix_d.depth = in_i.depth;
    unique case (seg)
      SEG_WHITE_RED: begin
        pix_d.red = CHAN_MAX; pix_d.green = lb_inv;   pix_d.blue = lb_inv;
      end
      SEG_RED_YELLOW: begin
        pix_d.red = CHAN_MAX; pix_d.green = lb;       pix_d.blue = '0;
      end
      SEG_YELLOW_GRN: begin
        pix_d.red = lb_inv;   pix_d.green = CHAN_MAX; pix_d.blue = '0;
      end
      SEG_GRN_CYAN: begin
        pix_d.red = '0;       pix_d.green = CHAN_MAX; pix_d.blue = lb;
      end
      SEG_CYAN_BLUE: begin
        pix_d.red = '0;       pix_d.green = lb_inv;   pix_d.blue = CHAN_MAX;
      end
      SEG_BLUE_DARK: begin
        pix_d.red = '0;       pix_d.green = '0;       pix_d.blue = lb_inv;
      end
      default: begin
        pix_d.red = '0;       pix_d.green = '0;       pix_d.blue = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix_q <= pix_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_o       = pix_q;

endmodule

[hw/rtl/depth_threshold_pseudocolor.sv]
// ----------------------------------------------------------------------------
// depth_threshold_pseudocolor
// Depth sample thresholding with cubic gamma and pseudocolor ramp.
//
// Usage:
//   s_axis carries one 11-bit depth sample per request. m_axis returns one
//   pixel per request: the thresholded depth and an 8-bit red, green and blue
//   value. The APB port holds depth_limit at address 0 (reset 1024); samples
//   above it are zeroed and come out white.
//   Four register stages: clamp and square, cube (the 22x11 multiplier),
//   scale and shift, color lookup into the output register. A request taken
//   at s_axis passes through them in order and shows on m_axis from the
//   output register. Throughput is one request per cycle if m_axis is ready.
//   A stalled receiver holds the output register; each stage keeps taking
//   requests while a bubble lies ahead of it, so input stays ready until all
//   four stages are full. Reset empties the pipeline and restores the limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module depth_threshold_pseudocolor
  import dtp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [10:0] depth_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [10:0] depth_out, [18:11] red_level,
                                      // [26:19] green_level, [34:27] blue_level
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [DEPTH_W-1:0] depth_limit;
  logic               g_valid, g_ready;
  gamma_t             g_data;
  pix_t               pix;

  dtp_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .depth_limit_o (depth_limit)
  );

  dtp_gamma u_gamma (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .depth_limit_i (depth_limit),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_depth_i    (s_axis_tdata[DEPTH_W-1:0]),
    .out_valid_o   (g_valid),
    .out_ready_i   (g_ready),
    .out_o         (g_data)
  );

  dtp_ramp u_ramp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (g_valid),
    .in_ready_o  (g_ready),
    .in_i        (g_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (pix)
  );

  assign m_axis_tdata = {5'b00000, pix};

  // empty output stage means every stage can advance
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output register empty");

  a_zero_is_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[10:0] == 11'd0) |->
      (m_axis_tdata[34:11] == 24'hFFFFFF))
    else $error("zero depth not white");

  // depth 1128 and up lands at level 1536 or higher
  a_far_is_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[10:0] >= 11'd1128) |->
      (m_axis_tdata[34:11] == 24'h000000))
    else $error("far depth not black");

endmodule
